// File: sv/lpd_pkg.sv
package lpd_pkg;

   localparam int HEADER_BYTES_DEF = 4;
   localparam int HEADER_BYTES_MAX = 4;
   localparam int COUNT_W = 3;
   localparam int LENGTH_W = 32;
   localparam int BYTE_W = 8;
   localparam logic [LENGTH_W-1:0] MAX_LENGTH_RESET = 32'd65535;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              has_byte;
      logic              last;
      logic              length_error;
   } rsp_type;

endpackage

// File: sv/lpd_out_queue.sv
module lpd_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lpd_pkg::rsp_type push_data,
   input  logic             pop,
   output logic             has_space,
   output logic             out_valid,
   output lpd_pkg::rsp_type out_data
);

   lpd_pkg::rsp_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign has_space = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/length_prefix_deframer.sv
// Length-prefixed stream deframer. Each packet on the byte stream opens with a
// little-endian header of HEADER_BYTES bytes giving the payload length, taken
// as unsigned; the payload bytes that follow are passed through one per
// transaction, and the final one is flagged last. A zero length gives a single
// empty transaction flagged last on the final header byte. A length above
// max_length gives a transaction with length_error set and no data; the
// payload bytes are still counted and passed on. One byte is taken every clock
// while req_stall is low: a byte is registered, decoded by the header/payload
// counters and written to a two-entry output queue, and a stall on the result
// side holds the input only once the queue is full. max_length is written
// through the csr port, which is always ready.
module length_prefix_deframer #(
   parameter int HEADER_BYTES = lpd_pkg::HEADER_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lpd_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lpd_pkg::BYTE_W-1:0]   rsp_payload_byte,
   output logic                         rsp_has_byte,
   output logic                         rsp_last,
   output logic                         rsp_length_error,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lpd_pkg::LENGTH_W-1:0] csr_max_length
);

   localparam logic [lpd_pkg::COUNT_W-1:0] HdrLastPos =
      lpd_pkg::COUNT_W'(HEADER_BYTES - 1);

   logic                          in_valid_ff;
   logic [lpd_pkg::BYTE_W-1:0]    in_byte_ff;
   logic [lpd_pkg::LENGTH_W-1:0]  max_length_ff;
   logic                          in_payload_ff;
   logic                          in_payload_in;
   logic [lpd_pkg::COUNT_W-1:0]   header_count_ff;
   logic [lpd_pkg::COUNT_W-1:0]   header_count_in;
   logic [lpd_pkg::LENGTH_W-1:0]  length_ff;
   logic [lpd_pkg::LENGTH_W-1:0]  length_in;
   logic [lpd_pkg::LENGTH_W-1:0]  bytes_left_ff;
   logic [lpd_pkg::LENGTH_W-1:0]  bytes_left_in;
   logic [lpd_pkg::LENGTH_W-1:0]  assembled;
   logic                          len_err;
   logic                          fin_payload;
   logic                          advance;
   logic                          push;
   logic                          has_space;
   lpd_pkg::rsp_type              rsp_in;
   lpd_pkg::rsp_type              rsp_out;

   assign advance   = in_valid_ff && has_space;
   assign req_stall = in_valid_ff && !has_space;
   assign csr_ready = 1'b1;

   always_comb begin
      assembled = (header_count_ff == '0) ? '0 : length_ff;
      for (int i = 0; i < lpd_pkg::HEADER_BYTES_MAX; i++) begin
         if (header_count_ff == lpd_pkg::COUNT_W'(i)) begin
            assembled[8*i +: 8] = assembled[8*i +: 8] | in_byte_ff;
         end
      end
   end

   assign len_err     = (assembled > max_length_ff);
   assign fin_payload = (bytes_left_ff <= lpd_pkg::LENGTH_W'(1));

   always_comb begin
      in_payload_in   = in_payload_ff;
      header_count_in = header_count_ff;
      length_in       = length_ff;
      bytes_left_in   = bytes_left_ff;
      push            = 1'b0;
      rsp_in          = '0;
      if (advance) begin
         if (in_payload_ff) begin
            push                = 1'b1;
            rsp_in.payload_byte = in_byte_ff;
            rsp_in.has_byte     = 1'b1;
            rsp_in.last         = fin_payload;
            if (fin_payload) begin
               bytes_left_in   = '0;
               in_payload_in   = 1'b0;
               header_count_in = '0;
            end else begin
               bytes_left_in = bytes_left_ff - lpd_pkg::LENGTH_W'(1);
            end
         end else begin
            length_in = assembled;
            if (header_count_ff < HdrLastPos) begin
               header_count_in = header_count_ff + lpd_pkg::COUNT_W'(1);
            end else begin
               header_count_in = '0;
               if (assembled == '0) begin
                  push                = 1'b1;
                  rsp_in.last         = 1'b1;
                  rsp_in.length_error = len_err;
                  in_payload_in       = 1'b0;
                  bytes_left_in       = '0;
               end else begin
                  in_payload_in = 1'b1;
                  bytes_left_in = assembled;
                  if (len_err) begin
                     push                = 1'b1;
                     rsp_in.length_error = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         max_length_ff   <= lpd_pkg::MAX_LENGTH_RESET;
         in_payload_ff   <= 1'b0;
         header_count_ff <= '0;
         length_ff       <= '0;
         bytes_left_ff   <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (csr_valid && csr_ready) begin
            max_length_ff <= csr_max_length;
         end
         in_payload_ff   <= in_payload_in;
         header_count_ff <= header_count_in;
         length_ff       <= length_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_data_byte;
      end
   end

   lpd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (rsp_in),
      .pop       (rsp_valid && !rsp_stall),
      .has_space (has_space),
      .out_valid (rsp_valid),
      .out_data  (rsp_out)
   );

   assign rsp_payload_byte = rsp_out.payload_byte;
   assign rsp_has_byte     = rsp_out.has_byte;
   assign rsp_last         = rsp_out.last;
   assign rsp_length_error = rsp_out.length_error;

endmodule

// File: sv/lpd_checker.sv
module lpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_has_byte,
   input logic       rsp_last,
   input logic       rsp_length_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_has_byte) && $stable(rsp_last) && $stable(rsp_length_error))
      else $error("stalled rsp transaction changed");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_payload_byte == 8'd0)
      else $error("marker transaction carries a nonzero byte");

   a_err_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_error |-> !rsp_has_byte && !rsp_last)
      else $error("length error on a data or last transaction");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_has_byte     (rsp_has_byte),
   .rsp_last         (rsp_last),
   .rsp_length_error (rsp_length_error)
);

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int HDR = lpd_pkg::HEADER_BYTES_DEF;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEM_TARGET = 1450;
   localparam int NUM_PHASES = 10;

   typedef enum {STIM_BYTE, STIM_CFG, STIM_DRAIN} stim_kind_type;
   typedef enum {STALL_NONE, STALL_SPARSE, STALL_RUNS, STALL_HEAVY} stall_mode_type;

   typedef struct {
      stim_kind_type kind;
      logic [31:0]   value;
   } stim_item_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [lpd_pkg::BYTE_W-1:0]   req_data_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [lpd_pkg::BYTE_W-1:0]   rsp_payload_byte;
   logic                         rsp_has_byte;
   logic                         rsp_last;
   logic                         rsp_length_error;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [lpd_pkg::LENGTH_W-1:0] csr_max_length = '0;

   length_prefix_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_last         (rsp_last),
      .rsp_length_error (rsp_length_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_length   (csr_max_length)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   stim_item_type    pending_stim[$];
   lpd_pkg::rsp_type expected_rsp[$];
   int               expect_count = 0;
   int               idle_cycles = 0;
   int               error_count = 0;

   // deframer prediction state
   logic                         fr_in_payload;
   logic [lpd_pkg::COUNT_W-1:0]  fr_hdr_count;
   logic [lpd_pkg::LENGTH_W-1:0] fr_length;
   logic [lpd_pkg::LENGTH_W-1:0] fr_left;
   logic [lpd_pkg::LENGTH_W-1:0] fr_max;

   // stream alignment tracking used while building stimulus
   bit          sh_in_pay;
   int          sh_pos;
   int unsigned sh_len;
   int unsigned sh_left;
   int          stim_bytes;

   function automatic lpd_pkg::rsp_type make_rsp(logic [7:0] b, logic has, logic lst,
                                                 logic err);
      lpd_pkg::rsp_type r;
      r.payload_byte = b;
      r.has_byte = has;
      r.last = lst;
      r.length_error = err;
      return r;
   endfunction

   function void deframe_byte(logic [7:0] b);
      int  p;
      logic err;
      if (fr_in_payload) begin
         expected_rsp.push_back(make_rsp(b, 1'b1, fr_left <= 1, 1'b0));
         if (fr_left <= 1) begin
            fr_left = '0;
            fr_in_payload = 1'b0;
            fr_hdr_count = '0;
         end else begin
            fr_left = fr_left - 1;
         end
         return;
      end
      p = int'(fr_hdr_count);
      if (p == 0) fr_length = '0;
      if (p < 4) fr_length = fr_length | (32'(b) << (8 * p));
      if (p + 1 < HDR) begin
         fr_hdr_count = lpd_pkg::COUNT_W'(p + 1);
         return;
      end
      fr_hdr_count = '0;
      err = (fr_length > fr_max);
      if (fr_length == 0) begin
         expected_rsp.push_back(make_rsp(8'h00, 1'b0, 1'b1, err));
         fr_in_payload = 1'b0;
         fr_left = '0;
      end else begin
         fr_in_payload = 1'b1;
         fr_left = fr_length;
         if (err) expected_rsp.push_back(make_rsp(8'h00, 1'b0, 1'b0, 1'b1));
      end
   endfunction

   function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch: expected %h actual %h", $realtime, name, want, got);
      end
   endfunction

   task push_byte(logic [7:0] b);
      stim_item_type it;
      it.kind = STIM_BYTE;
      it.value = 32'(b);
      pending_stim.push_back(it);
      stim_bytes++;
      if (sh_in_pay) begin
         sh_left--;
         if (sh_left == 0) sh_in_pay = 0;
      end else begin
         if (sh_pos == 0) sh_len = 0;
         sh_len = sh_len | (int'(b) << (8 * sh_pos));
         sh_pos++;
         if (sh_pos == HDR) begin
            sh_pos = 0;
            if (sh_len != 0) begin
               sh_in_pay = 1;
               sh_left = sh_len;
            end
         end
      end
   endtask

   task push_ctrl(stim_kind_type kind, logic [31:0] value);
      stim_item_type it;
      it.kind = kind;
      it.value = value;
      pending_stim.push_back(it);
   endtask

   // keep header bytes from a misaligned stream small so lengths stay short
   function automatic logic [7:0] noise_byte();
      if (sh_in_pay || sh_pos == 0) return 8'($urandom_range(0, 255));
      if (sh_pos == 1) return ($urandom_range(0, 7) == 0) ? 8'h01 : 8'h00;
      return 8'h00;
   endfunction

   task push_packet(int unsigned len);
      for (int i = 0; i < HDR; i++) push_byte(8'(len >> (8 * i)));
      for (int unsigned i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
   endtask

   task realign();
      while (sh_in_pay || sh_pos != 0) push_byte(noise_byte());
   endtask

   function automatic logic [31:0] pick_max(int phase);
      case (phase)
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'd1;
         3: return 32'd65535;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'($urandom_range(0, 20));
               1: return $urandom;
               2: return 32'($urandom_range(0, 8));
               default: return 32'd16;
            endcase
         end
      endcase
   endfunction

   initial begin
      int phase_start;
      int unsigned len;
      int r;
      sh_in_pay = 0;
      sh_pos = 0;
      sh_len = 0;
      sh_left = 0;
      stim_bytes = 0;

      push_byte(8'h02); push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
      push_byte(8'h00); push_byte(8'hFF);
      push_packet(0);
      push_ctrl(STIM_CFG, 32'd3);
      push_packet(3);
      push_packet(4);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         push_ctrl(STIM_CFG, pick_max(ph));
         phase_start = stim_bytes;
         while (stim_bytes - phase_start < ITEM_TARGET / NUM_PHASES) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               repeat ($urandom_range(1, 8)) push_byte(noise_byte());
            end else begin
               realign();
               r = $urandom_range(0, 99);
               if (r < 10) len = 0;
               else if (r < 95) len = $urandom_range(1, 16);
               else len = $urandom_range(17, 300);
               push_packet(len);
            end
            if ($urandom_range(0, 19) == 0) push_ctrl(STIM_DRAIN, '0);
         end
      end

      realign();
      push_ctrl(STIM_CFG, 32'hFFFF_FFFE);
      repeat (HDR) push_byte(8'hFF);
      repeat (10) push_byte(8'($urandom_range(0, 255)));

      do @(negedge clock);
      while (reset || pending_stim.size() != 0 || req_valid || csr_valid || expect_count != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("length_prefix_deframer regression: pass");
      end else begin
         $display("length_prefix_deframer regression: fail");
      end
      $finish;
   end

   int burst_left;
   int gap_left;
   int quiet;

   always @(posedge clock) begin
      logic                       nv;
      logic                       ncv;
      logic [lpd_pkg::BYTE_W-1:0] nd;
      logic [31:0]                ncd;
      if (reset) begin
         req_valid <= 1'b0;
         req_data_byte <= '0;
         csr_valid <= 1'b0;
         csr_max_length <= '0;
         burst_left = $urandom_range(1, 30);
         gap_left = 0;
         quiet = 0;
      end else begin
         nv = req_valid;
         nd = req_data_byte;
         ncv = csr_valid;
         ncd = csr_max_length;
         if (req_valid && !req_stall) nv = 1'b0;
         if (csr_valid && csr_ready) ncv = 1'b0;
         if (!req_valid && !csr_valid && expect_count == 0) quiet++;
         else quiet = 0;
         if (!nv && !ncv && pending_stim.size() != 0) begin
            case (pending_stim[0].kind)
               STIM_BYTE: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     nv = 1'b1;
                     nd = pending_stim[0].value[7:0];
                     void'(pending_stim.pop_front());
                     burst_left--;
                     if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                     end
                  end
               end
               STIM_CFG: begin
                  if (quiet >= SETTLE_CYCLES) begin
                     ncv = 1'b1;
                     ncd = pending_stim[0].value;
                     void'(pending_stim.pop_front());
                  end
               end
               default: begin
                  if (quiet >= SETTLE_CYCLES) void'(pending_stim.pop_front());
               end
            endcase
         end
         req_valid <= nv;
         req_data_byte <= nd;
         csr_valid <= ncv;
         csr_max_length <= ncd;
      end
   end

   stall_mode_type stall_mode;
   int             mode_left;
   int             run_left;
   logic           run_level;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode = STALL_NONE;
         mode_left = 50;
         run_left = 0;
         run_level = 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_RUNS: begin
               if (run_left == 0) begin
                  run_level = !run_level;
                  run_left = $urandom_range(1, 24);
               end else begin
                  run_left--;
               end
               rsp_stall <= run_level;
            end
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      lpd_pkg::rsp_type want;
      if (reset) begin
         fr_in_payload = 1'b0;
         fr_hdr_count = '0;
         fr_length = '0;
         fr_left = '0;
         fr_max = lpd_pkg::MAX_LENGTH_RESET;
         expected_rsp.delete();
         expect_count <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               error_count++;
               $display({"%0t: unexpected transaction: expected none ",
                         "actual byte %h has %b last %b err %b"},
                        $realtime, rsp_payload_byte, rsp_has_byte, rsp_last,
                        rsp_length_error);
            end else begin
               want = expected_rsp.pop_front();
               check_field("payload_byte", want.payload_byte, rsp_payload_byte);
               check_field("has_byte", 8'(want.has_byte), 8'(rsp_has_byte));
               check_field("last", 8'(want.last), 8'(rsp_last));
               check_field("length_error", 8'(want.length_error), 8'(rsp_length_error));
            end
         end
         if (csr_valid && csr_ready) fr_max = csr_max_length;
         if (req_valid && !req_stall) deframe_byte(req_data_byte);
         expect_count <= expected_rsp.size();
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("length_prefix_deframer regression: fail");
         $finish;
      end
   end

endmodule
